>>> design/lrbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbc_pkg
// Shared codes and control types for the link reconnect backoff controller.
// ----------------------------------------------------------------------------
package lrbc_pkg;

  localparam int unsigned MsW     = 31;  // millisecond register width
  localparam int unsigned TimeW   = 32;  // wrapping time and random word width
  localparam int unsigned FactorW = 12;  // Q4.8 growth factor
  localparam int unsigned FracW   = 8;   // Q0.8 jitter fraction
  localparam int unsigned OpW     = 3;
  localparam int unsigned StateW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DivCntW = $clog2(TimeW);

  // event codes
  localparam logic [OpW-1:0] OP_TICK       = 3'd0;
  localparam logic [OpW-1:0] OP_ACTIVATE   = 3'd1;
  localparam logic [OpW-1:0] OP_DEACTIVATE = 3'd2;
  localparam logic [OpW-1:0] OP_LINK_LOST  = 3'd3;
  localparam logic [OpW-1:0] OP_ADDR_ACQ   = 3'd4;

  // link state codes
  localparam logic [StateW-1:0] LS_INACTIVE     = 3'd0;
  localparam logic [StateW-1:0] LS_DISCONNECTED = 3'd1;
  localparam logic [StateW-1:0] LS_CONNECTING   = 3'd2;
  localparam logic [StateW-1:0] LS_BACKOFF      = 3'd3;
  localparam logic [StateW-1:0] LS_CONNECTED    = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_INIT_BACKOFF   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_BACKOFF    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BACKOFF_FACTOR = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_JITTER_FRAC    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FAST_TIMEOUT   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_NORMAL_TIMEOUT = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_CACHE_VALID    = 3'd6;

  // reset values of the configuration registers
  localparam logic [MsW-1:0]     RST_INIT_BACKOFF   = 31'd1000;
  localparam logic [MsW-1:0]     RST_MAX_BACKOFF    = 31'd60000;
  localparam logic [FactorW-1:0] RST_BACKOFF_FACTOR = 12'd512;
  localparam logic [FracW-1:0]   RST_JITTER_FRAC    = 8'd64;
  localparam logic [MsW-1:0]     RST_FAST_TIMEOUT   = 31'd4000;
  localparam logic [MsW-1:0]     RST_NORMAL_TIMEOUT = 31'd30000;

  typedef struct packed {
    logic capture;   // latch the accepted item
    logic eval;      // apply the event update
    logic grow;      // multiply backoff by the growth factor, saturate
    logic half;      // compute jitter half-width, arm the divider
    logic div_step;  // one restoring division step
    logic finish;    // apply offset, clamp, enter backoff
    logic publish;   // load the result register
  } lrbc_cmd_t;

  typedef struct packed {
    logic need_grow;  // link lost during a normal attempt
    logic div_last;   // final division step this cycle
  } lrbc_stat_t;

endpackage

>>> design/link_reconnect_backoff_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_reconnect_backoff_controller_core
// Link reconnect controller with exponential backoff and random spread.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the input channel (op, now_ms, random_word) under
//   valid/ready; each item yields exactly one result on the output channel
//   (link_state, start_attempt, fast_attempt, wait_ms, backoff_ms).
//   Configuration is a write-only port (cfg_we_i, cfg_index_i, cfg_data_i);
//   the user writes it only while the block is idle; the block does not enforce this.
//   Steps: most events pass through the event update and then the result
//   load; a link loss during a normal attempt also runs grow, half-width,
//   the 32-step bit-serial modulo that draws the jitter offset, and clamp
//   before the result load.
//   One item at a time; the next item is taken only after the result of
//   the previous one has been loaded into the output register.
//   A result waits in the output register while the receiver stalls; the
//   next item is accepted and worked on meanwhile and holds only at the
//   point where its result would be loaded.
//   Reset puts the link inactive, clears the backoff state and loads the
//   register defaults.
// ----------------------------------------------------------------------------
module link_reconnect_backoff_controller_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lrbc_pkg::OpW-1:0]     op_i,
  input  logic [lrbc_pkg::TimeW-1:0]   now_ms_i,
  input  logic [lrbc_pkg::TimeW-1:0]   random_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lrbc_pkg::StateW-1:0]  link_state_o,
  output logic                         start_attempt_o,
  output logic                         fast_attempt_o,
  output logic [lrbc_pkg::MsW-1:0]     wait_ms_o,
  output logic [lrbc_pkg::MsW-1:0]     backoff_ms_o,
  input  logic                         cfg_we_i,
  input  logic [lrbc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lrbc_pkg::MsW-1:0]     cfg_data_i
);

  lrbc_pkg::lrbc_cmd_t  cmd;
  lrbc_pkg::lrbc_stat_t stat;

  lrbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lrbc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .now_ms_i        (now_ms_i),
    .random_word_i   (random_word_i),
    .link_state_o    (link_state_o),
    .start_attempt_o (start_attempt_o),
    .fast_attempt_o  (fast_attempt_o),
    .wait_ms_o       (wait_ms_o),
    .backoff_ms_o    (backoff_ms_o)
  );

endmodule

>>> design/lrbc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbc_datapath
// Configuration registers, link state, backoff arithmetic with a bit-serial
// modulo unit, and the result register.
// ----------------------------------------------------------------------------
module lrbc_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lrbc_pkg::lrbc_cmd_t          cmd_i,
  output lrbc_pkg::lrbc_stat_t         stat_o,
  input  logic                         cfg_we_i,
  input  logic [lrbc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lrbc_pkg::MsW-1:0]     cfg_data_i,
  input  logic [lrbc_pkg::OpW-1:0]     op_i,
  input  logic [lrbc_pkg::TimeW-1:0]   now_ms_i,
  input  logic [lrbc_pkg::TimeW-1:0]   random_word_i,
  output logic [lrbc_pkg::StateW-1:0]  link_state_o,
  output logic                         start_attempt_o,
  output logic                         fast_attempt_o,
  output logic [lrbc_pkg::MsW-1:0]     wait_ms_o,
  output logic [lrbc_pkg::MsW-1:0]     backoff_ms_o
);

  localparam int unsigned MsW   = lrbc_pkg::MsW;
  localparam int unsigned TimeW = lrbc_pkg::TimeW;
  localparam int unsigned FacW  = lrbc_pkg::FactorW;
  localparam int unsigned FrW   = lrbc_pkg::FracW;
  localparam int unsigned SumW  = TimeW + 2;

  // configuration
  logic [MsW-1:0]  init_q, max_q, fast_to_q, norm_to_q;
  logic [FacW-1:0] factor_q;
  logic [FrW-1:0]  frac_q;
  logic            cache_q;

  // link state
  logic [lrbc_pkg::StateW-1:0] mode_q;
  logic                        requested_q, fast_q;
  logic [MsW-1:0]              backoff_q, wait_q;
  logic [TimeW-1:0]            start_q;
  logic                        started_q, fast_start_q;

  // latched item
  logic [lrbc_pkg::OpW-1:0] op_q;
  logic [TimeW-1:0]         now_q, rnd_q;

  // arithmetic
  logic [MsW-1:0]                 half_q;
  logic [TimeW-1:0]               rem_q, dvd_q;
  logic [lrbc_pkg::DivCntW-1:0]   cnt_q;

  logic [MsW+FacW-1:0]   grow_prod;
  logic [MsW+FacW-9:0]   grown;
  logic [MsW+FrW-1:0]    half_prod;
  logic [TimeW-1:0]      span, rem_d;
  logic [TimeW:0]        rem_shift;
  logic [TimeW-1:0]      elapsed;
  logic [MsW-1:0]        limit;
  logic signed [SumW-1:0] total, low_clamped, init_s, max_s;
  logic [MsW-1:0]        wait_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= lrbc_pkg::RST_INIT_BACKOFF;
      max_q     <= lrbc_pkg::RST_MAX_BACKOFF;
      factor_q  <= lrbc_pkg::RST_BACKOFF_FACTOR;
      frac_q    <= lrbc_pkg::RST_JITTER_FRAC;
      fast_to_q <= lrbc_pkg::RST_FAST_TIMEOUT;
      norm_to_q <= lrbc_pkg::RST_NORMAL_TIMEOUT;
      cache_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lrbc_pkg::CFG_INIT_BACKOFF:   init_q    <= cfg_data_i;
        lrbc_pkg::CFG_MAX_BACKOFF:    max_q     <= cfg_data_i;
        lrbc_pkg::CFG_BACKOFF_FACTOR: factor_q  <= cfg_data_i[FacW-1:0];
        lrbc_pkg::CFG_JITTER_FRAC:    frac_q    <= cfg_data_i[FrW-1:0];
        lrbc_pkg::CFG_FAST_TIMEOUT:   fast_to_q <= cfg_data_i;
        lrbc_pkg::CFG_NORMAL_TIMEOUT: norm_to_q <= cfg_data_i;
        lrbc_pkg::CFG_CACHE_VALID:    cache_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign elapsed   = now_q - start_q;
  assign limit     = fast_q ? fast_to_q : norm_to_q;
  assign grow_prod = backoff_q * factor_q;
  assign grown     = grow_prod[MsW+FacW-1:8];
  assign half_prod = backoff_q * frac_q;

  // span = 2*half + 1, always nonzero; half of zero gives a zero offset
  assign span      = {half_q, 1'b1};
  assign rem_shift = {rem_q, dvd_q[TimeW-1]};
  assign rem_d     = (rem_shift >= {1'b0, span}) ? TimeW'(rem_shift - {1'b0, span})
                                                 : rem_shift[TimeW-1:0];

  assign init_s = signed'({3'b000, init_q});
  assign max_s  = signed'({3'b000, max_q});
  assign total  = signed'({3'b000, backoff_q}) + signed'({2'b00, rem_q})
                - signed'({3'b000, half_q});
  assign low_clamped = (total < init_s) ? init_s : total;
  assign wait_new    = (low_clamped > max_s) ? max_q : low_clamped[MsW-1:0];

  assign stat_o.need_grow = (op_q == lrbc_pkg::OP_LINK_LOST) &&
                            (mode_q == lrbc_pkg::LS_CONNECTING) && !fast_q;
  assign stat_o.div_last  = (cnt_q == lrbc_pkg::DivCntW'(TimeW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= lrbc_pkg::LS_INACTIVE;
      requested_q  <= 1'b0;
      fast_q       <= 1'b0;
      backoff_q    <= '0;
      wait_q       <= '0;
      start_q      <= '0;
      started_q    <= 1'b0;
      fast_start_q <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        started_q    <= 1'b0;
        fast_start_q <= 1'b0;
        unique case (op_q)
          lrbc_pkg::OP_TICK: begin
            if (requested_q) begin
              priority if (mode_q == lrbc_pkg::LS_DISCONNECTED) begin
                mode_q       <= lrbc_pkg::LS_CONNECTING;
                start_q      <= now_q;
                started_q    <= 1'b1;
                fast_start_q <= fast_q & cache_q;
              end else if (mode_q == lrbc_pkg::LS_CONNECTING) begin
                if (elapsed > {1'b0, limit}) begin
                  if (fast_q) begin
                    // fall back to a normal attempt
                    fast_q <= 1'b0;
                    mode_q <= lrbc_pkg::LS_DISCONNECTED;
                  end else begin
                    mode_q  <= lrbc_pkg::LS_BACKOFF;
                    start_q <= now_q;
                  end
                end
              end else if (mode_q == lrbc_pkg::LS_BACKOFF) begin
                if (elapsed >= {1'b0, wait_q}) begin
                  fast_q <= 1'b0;
                  mode_q <= lrbc_pkg::LS_DISCONNECTED;
                end
              end else begin
              end
            end
          end
          lrbc_pkg::OP_ACTIVATE: begin
            if (mode_q == lrbc_pkg::LS_INACTIVE) begin
              requested_q <= 1'b1;
              mode_q      <= lrbc_pkg::LS_DISCONNECTED;
              fast_q      <= cache_q;
              backoff_q   <= init_q;
              wait_q      <= init_q;
            end
          end
          lrbc_pkg::OP_DEACTIVATE: begin
            requested_q <= 1'b0;
            mode_q      <= lrbc_pkg::LS_INACTIVE;
          end
          lrbc_pkg::OP_LINK_LOST: begin
            // normal attempt loss goes through the grow sequence instead
            priority if (mode_q == lrbc_pkg::LS_CONNECTING) begin
              if (fast_q) begin
                fast_q <= 1'b0;
                mode_q <= lrbc_pkg::LS_DISCONNECTED;
              end
            end else if (mode_q == lrbc_pkg::LS_DISCONNECTED ||
                         mode_q == lrbc_pkg::LS_CONNECTED) begin
              mode_q <= lrbc_pkg::LS_DISCONNECTED;
            end else begin
            end
          end
          lrbc_pkg::OP_ADDR_ACQ: begin
            if (mode_q != lrbc_pkg::LS_INACTIVE) begin
              mode_q    <= lrbc_pkg::LS_CONNECTED;
              backoff_q <= init_q;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.grow) begin
        backoff_q <= (grown > {4'b0000, max_q}) ? max_q : grown[MsW-1:0];
      end
      if (cmd_i.finish) begin
        wait_q  <= wait_new;
        mode_q  <= lrbc_pkg::LS_BACKOFF;
        start_q <= now_q;
      end
    end
  end

  // item latch, modulo unit and result register carry no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      now_q <= now_ms_i;
      rnd_q <= random_word_i;
    end
    if (cmd_i.half) begin
      half_q <= half_prod[MsW+FrW-1:8];
      rem_q  <= '0;
      dvd_q  <= rnd_q;
      cnt_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[TimeW-2:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.publish) begin
      link_state_o    <= mode_q;
      start_attempt_o <= started_q;
      fast_attempt_o  <= fast_start_q;
      wait_ms_o       <= wait_q;
      backoff_ms_o    <= backoff_q;
    end
  end

endmodule

>>> design/lrbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbc_ctrl
// Sequencer: item handshake, event update, grow/draw sequence and the
// result valid flag.
// ----------------------------------------------------------------------------
module lrbc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  lrbc_pkg::lrbc_stat_t stat_i,
  output lrbc_pkg::lrbc_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_GROW,
    S_HALF,
    S_DIV,
    S_FINISH,
    S_PUB
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   pub_ok;

  assign pub_ok = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.eval     = (state_q == S_EVAL);
    cmd_o.grow     = (state_q == S_GROW);
    cmd_o.half     = (state_q == S_HALF);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.finish   = (state_q == S_FINISH);
    cmd_o.publish  = (state_q == S_PUB) && pub_ok;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // drop the result once taken; a new publish refills it
      if (cmd_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= S_EVAL;
        S_EVAL:   state_q <= stat_i.need_grow ? S_GROW : S_PUB;
        S_GROW:   state_q <= S_HALF;
        S_HALF:   state_q <= S_DIV;
        S_DIV:    if (stat_i.div_last) state_q <= S_FINISH;
        S_FINISH: state_q <= S_PUB;
        S_PUB:    if (pub_ok) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/lrbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbc_checker
// Port-level checks on the link reconnect controller.
// ----------------------------------------------------------------------------
module lrbc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [lrbc_pkg::StateW-1:0] link_state_o,
  input logic                        start_attempt_o,
  input logic                        fast_attempt_o,
  input logic [lrbc_pkg::MsW-1:0]    wait_ms_o,
  input logic [lrbc_pkg::MsW-1:0]    backoff_ms_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(link_state_o) &&
      $stable(start_attempt_o) && $stable(fast_attempt_o) &&
      $stable(wait_ms_o) && $stable(backoff_ms_o))
    else $error("result changed while stalled");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fast_attempt_o |-> start_attempt_o)
    else $error("fast attempt flagged without a started attempt");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_attempt_o |-> link_state_o == lrbc_pkg::LS_CONNECTING)
    else $error("attempt started outside the connecting state");

endmodule

bind link_reconnect_backoff_controller_core lrbc_checker u_lrbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .link_state_o    (link_state_o),
  .start_attempt_o (start_attempt_o),
  .fast_attempt_o  (fast_attempt_o),
  .wait_ms_o       (wait_ms_o),
  .backoff_ms_o    (backoff_ms_o)
);

>>> tb/sv/link_reconnect_backoff_controller_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_reconnect_backoff_controller_core_tb
// Drives link events through the reconnect controller under random valid and
// ready gaps. A scoreboard runs a cycle-free copy of the controller state and
// compares each result, field by field, against the expectation in order.
// ----------------------------------------------------------------------------
module link_reconnect_backoff_controller_core_tb;
  import lrbc_pkg::*;

  localparam logic [OpW-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OpW-1:0] OP_UNUSED_HI = 3'd7;
  localparam int unsigned    CycleLimit   = 600000;
  localparam int unsigned    DrainCycles  = 50;
  localparam int unsigned    LongHold     = 300;
  localparam int unsigned    PhaseEvents  = 250;

  typedef struct packed {
    logic [StateW-1:0] link_state;
    logic              start_attempt;
    logic              fast_attempt;
    logic [MsW-1:0]    wait_ms;
    logic [MsW-1:0]    backoff_ms;
  } link_result_t;

  typedef struct {
    logic [MsW-1:0]     init_ms;
    logic [MsW-1:0]     max_ms;
    logic [FactorW-1:0] factor;
    logic [FracW-1:0]   jfrac;
    logic [MsW-1:0]     fast_to;
    logic [MsW-1:0]     normal_to;
    logic               cache_ok;
  } backoff_setting_t;

  class link_scoreboard;
    logic [MsW-1:0]     init_ms, max_ms, fast_to, normal_to;
    logic [FactorW-1:0] factor;
    logic [FracW-1:0]   jfrac;
    logic               cache_ok;
    logic [StateW-1:0]  mode;
    logic               requested, fast_flag;
    logic [MsW-1:0]     backoff_ms, wait_ms;
    logic [TimeW-1:0]   attempt_start;
    link_result_t       pending_q[$];
    int unsigned        mismatches;

    function new();
      init_ms       = RST_INIT_BACKOFF;
      max_ms        = RST_MAX_BACKOFF;
      factor        = RST_BACKOFF_FACTOR;
      jfrac         = RST_JITTER_FRAC;
      fast_to       = RST_FAST_TIMEOUT;
      normal_to     = RST_NORMAL_TIMEOUT;
      cache_ok      = 1'b0;
      mode          = LS_INACTIVE;
      requested     = 1'b0;
      fast_flag     = 1'b0;
      backoff_ms    = '0;
      wait_ms       = '0;
      attempt_start = '0;
      mismatches    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [MsW-1:0] data);
      case (idx)
        CFG_INIT_BACKOFF:   init_ms   = data;
        CFG_MAX_BACKOFF:    max_ms    = data;
        CFG_BACKOFF_FACTOR: factor    = data[FactorW-1:0];
        CFG_JITTER_FRAC:    jfrac     = data[FracW-1:0];
        CFG_FAST_TIMEOUT:   fast_to   = data;
        CFG_NORMAL_TIMEOUT: normal_to = data;
        CFG_CACHE_VALID:    cache_ok  = data[0];
        default: ;
      endcase
    endfunction

    // Apply one accepted event and queue the result it must produce.
    function void note_event(logic [OpW-1:0] op, logic [TimeW-1:0] t,
                             logic [TimeW-1:0] rnd);
      logic [TimeW-1:0]  elapsed;
      logic [MsW-1:0]    limit;
      logic              started, fast_start;
      longint unsigned   grown, half, span;
      longint            offset, total, init_s, max_s;
      link_result_t      res;
      started    = 1'b0;
      fast_start = 1'b0;
      elapsed    = t - attempt_start;
      case (op)
        OP_TICK: begin
          if (requested) begin
            if (mode == LS_DISCONNECTED) begin
              mode          = LS_CONNECTING;
              attempt_start = t;
              started       = 1'b1;
              fast_start    = fast_flag & cache_ok;
            end else if (mode == LS_CONNECTING) begin
              limit = fast_flag ? fast_to : normal_to;
              if (elapsed > {1'b0, limit}) begin
                if (fast_flag) begin
                  fast_flag = 1'b0;
                  mode      = LS_DISCONNECTED;
                end else begin
                  mode          = LS_BACKOFF;
                  attempt_start = t;
                end
              end
            end else if (mode == LS_BACKOFF) begin
              if (elapsed >= {1'b0, wait_ms}) begin
                fast_flag = 1'b0;
                mode      = LS_DISCONNECTED;
              end
            end
          end
        end
        OP_ACTIVATE: begin
          if (mode == LS_INACTIVE) begin
            requested  = 1'b1;
            mode       = LS_DISCONNECTED;
            fast_flag  = cache_ok;
            backoff_ms = init_ms;
            wait_ms    = init_ms;
          end
        end
        OP_DEACTIVATE: begin
          requested = 1'b0;
          mode      = LS_INACTIVE;
        end
        OP_LINK_LOST: begin
          if (mode == LS_CONNECTING) begin
            if (fast_flag) begin
              fast_flag = 1'b0;
              mode      = LS_DISCONNECTED;
            end else begin
              // grow and saturate, then draw the jittered wait and clamp it
              grown = ({33'b0, backoff_ms} * {52'b0, factor}) >> 8;
              if (grown > {33'b0, max_ms}) grown = {33'b0, max_ms};
              backoff_ms = grown[MsW-1:0];
              half   = ({33'b0, backoff_ms} * {56'b0, jfrac}) >> 8;
              offset = 0;
              if (half > 0) begin
                span   = 2 * half + 1;
                offset = longint'({32'b0, rnd} % span) - longint'(half);
              end
              init_s = {33'b0, init_ms};
              max_s  = {33'b0, max_ms};
              total  = longint'({33'b0, backoff_ms}) + offset;
              if (total < init_s) total = init_s;
              if (total > max_s) total = max_s;
              wait_ms       = total[MsW-1:0];
              mode          = LS_BACKOFF;
              attempt_start = t;
            end
          end else if (mode == LS_DISCONNECTED || mode == LS_CONNECTED) begin
            mode = LS_DISCONNECTED;
          end
        end
        OP_ADDR_ACQ: begin
          if (mode != LS_INACTIVE) begin
            mode       = LS_CONNECTED;
            backoff_ms = init_ms;
          end
        end
        default: ;
      endcase
      res.link_state    = mode;
      res.start_attempt = started;
      res.fast_attempt  = fast_start;
      res.wait_ms       = wait_ms;
      res.backoff_ms    = backoff_ms;
      pending_q.push_back(res);
    endfunction

    function void check_result(link_result_t got);
      link_result_t want;
      logic         bad;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result: state %0d start %0d fast %0d wait %0d backoff %0d",
                   $time, got.link_state, got.start_attempt, got.fast_attempt,
                   got.wait_ms, got.backoff_ms);
        return;
      end
      want = pending_q.pop_front();
      bad = (want.link_state !== got.link_state) ||
            (want.start_attempt !== got.start_attempt) ||
            (want.fast_attempt !== got.fast_attempt) ||
            (want.wait_ms !== got.wait_ms) ||
            (want.backoff_ms !== got.backoff_ms);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected state %0d start %0d fast %0d wait %0d backoff %0d",
                   $time, want.link_state, want.start_attempt, want.fast_attempt,
                   want.wait_ms, want.backoff_ms);
          $display("%0t:   actual state %0d start %0d fast %0d wait %0d backoff %0d",
                   $time, got.link_state, got.start_attempt, got.fast_attempt,
                   got.wait_ms, got.backoff_ms);
        end
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [OpW-1:0]      op_i          = OP_TICK;
  logic [TimeW-1:0]    now_ms_i      = '0;
  logic [TimeW-1:0]    random_word_i = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [StateW-1:0]   link_state_o;
  logic                start_attempt_o;
  logic                fast_attempt_o;
  logic [MsW-1:0]      wait_ms_o;
  logic [MsW-1:0]      backoff_ms_o;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = CFG_INIT_BACKOFF;
  logic [MsW-1:0]      cfg_data_i    = '0;

  link_scoreboard      sb = new();
  backoff_setting_t    cur;
  logic [TimeW-1:0]    clock_ms;
  bit                  calm = 1'b0;
  int unsigned         hold_requests = 0;
  int unsigned         holds_done = 0;
  int unsigned         stall_left = 0;
  int unsigned         cycle_count = 0;

  link_reconnect_backoff_controller_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .now_ms_i       (now_ms_i),
    .random_word_i  (random_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .link_state_o   (link_state_o),
    .start_attempt_o(start_attempt_o),
    .fast_attempt_o (fast_attempt_o),
    .wait_ms_o      (wait_ms_o),
    .backoff_ms_o   (backoff_ms_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (holds_done != hold_requests) begin
      holds_done = hold_requests;
      stall_left = LongHold;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(99) < 26) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_event(op_i, now_ms_i, random_word_i);
      if (out_valid_o && out_ready_i)
        sb.check_result('{link_state: link_state_o, start_attempt: start_attempt_o,
                          fast_attempt: fast_attempt_o, wait_ms: wait_ms_o,
                          backoff_ms: backoff_ms_o});
    end
  end

  // Offer one item and hold it until accepted; valid stays high afterward.
  task automatic send_event(input logic [OpW-1:0] op, input logic [TimeW-1:0] t,
                            input logic [TimeW-1:0] rnd);
    if (!calm && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    now_ms_i      <= t;
    random_word_i <= rnd;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every result is back and the block is quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MsW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic load_setting(input backoff_setting_t s);
    write_reg(CFG_INIT_BACKOFF, s.init_ms);
    write_reg(CFG_MAX_BACKOFF, s.max_ms);
    write_reg(CFG_BACKOFF_FACTOR, MsW'(s.factor));
    write_reg(CFG_JITTER_FRAC, MsW'(s.jfrac));
    write_reg(CFG_FAST_TIMEOUT, s.fast_to);
    write_reg(CFG_NORMAL_TIMEOUT, s.normal_to);
    write_reg(CFG_CACHE_VALID, MsW'(s.cache_ok));
    cfg_we_i <= 1'b0;
    cur = s;
  endtask

  task automatic random_events(input int unsigned count);
    logic [OpW-1:0]   op;
    logic [TimeW-1:0] step;
    int unsigned      pick;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 50)      op = OP_TICK;
      else if (pick < 68) op = OP_LINK_LOST;
      else if (pick < 77) op = OP_ADDR_ACQ;
      else if (pick < 88) op = OP_ACTIVATE;
      else if (pick < 96) op = OP_DEACTIVATE;
      else                op = OpW'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      // advance time: small steps, steps right at a timeout or wait edge, large jumps or a random time
      pick = $urandom_range(99);
      if (pick < 40) begin
        clock_ms += $urandom_range(300);
      end else if (pick < 75) begin
        case ($urandom_range(3))
          0:       step = {1'b0, cur.fast_to};
          1:       step = {1'b0, cur.normal_to};
          2:       step = {1'b0, cur.init_ms};
          default: step = {1'b0, cur.max_ms};
        endcase
        clock_ms += step + $urandom_range(2);
      end else if (pick < 92) begin
        clock_ms += $urandom_range(200000);
      end else begin
        clock_ms = $urandom;
      end
      send_event(op, clock_ms, $urandom);
    end
  endtask

  initial begin
    backoff_setting_t s;
    cur = '{RST_INIT_BACKOFF, RST_MAX_BACKOFF, RST_BACKOFF_FACTOR, RST_JITTER_FRAC,
            RST_FAST_TIMEOUT, RST_NORMAL_TIMEOUT, 1'b0};
    clock_ms = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults, no cached address: normal attempts, timeouts, growth
    send_event(OP_TICK, 32'd10, 32'd0);
    send_event(OP_LINK_LOST, 32'd20, 32'd0);
    send_event(OP_ADDR_ACQ, 32'd30, 32'd0);
    send_event(OP_UNUSED_LO, 32'd40, 32'd0);
    send_event(OP_UNUSED_HI, 32'd50, 32'd0);
    send_event(OP_ACTIVATE, 32'd100, 32'd0);
    send_event(OP_ACTIVATE, 32'd110, 32'd0);
    send_event(OP_TICK, 32'd200, 32'd0);
    send_event(OP_TICK, 32'd30200, 32'd0);
    send_event(OP_TICK, 32'd30201, 32'd0);
    send_event(OP_TICK, 32'd31200, 32'd0);
    send_event(OP_TICK, 32'd31201, 32'd0);
    send_event(OP_TICK, 32'd31300, 32'd0);
    send_event(OP_LINK_LOST, 32'd31400, 32'd0);
    send_event(OP_LINK_LOST, 32'd31500, 32'hFFFF_FFFF);
    send_event(OP_TICK, 32'd40000, 32'd0);
    send_event(OP_TICK, 32'd40010, 32'd0);
    send_event(OP_LINK_LOST, 32'd40020, 32'd2000);
    send_event(OP_ADDR_ACQ, 32'd40100, 32'd0);
    send_event(OP_LINK_LOST, 32'd40200, 32'd0);
    send_event(OP_DEACTIVATE, 32'd40300, 32'd0);
    settle();

    // cached address: fast attempt, its timeout across the time wrap, fast loss
    s = cur;
    s.cache_ok = 1'b1;
    load_setting(s);
    send_event(OP_ACTIVATE, 32'hFFFF_F000, 32'd0);
    send_event(OP_TICK, 32'hFFFF_F000, 32'd0);
    send_event(OP_TICK, 32'h0000_0100, 32'd0);
    send_event(OP_TICK, 32'h0000_0200, 32'd0);
    send_event(OP_DEACTIVATE, 32'h0000_0300, 32'd0);
    send_event(OP_ACTIVATE, 32'd1000, 32'd0);
    send_event(OP_TICK, 32'd1100, 32'd0);
    send_event(OP_LINK_LOST, 32'd1200, 32'd0);
    clock_ms = 32'd1200;

    for (int ph = 0; ph < 7; ph++) begin
      settle();
      case (ph)
        0: ;  // keep defaults with a cached address
        1, 6: begin
          s.init_ms   = MsW'($urandom_range(1, 5000));
          s.max_ms    = MsW'($urandom_range(s.init_ms, 200000));
          s.factor    = FactorW'($urandom_range(256, 1024));
          s.jfrac     = FracW'($urandom);
          s.fast_to   = MsW'($urandom_range(100, 10000));
          s.normal_to = MsW'($urandom_range(1000, 60000));
          s.cache_ok  = 1'($urandom);
        end
        2: s = '{'0, '0, '0, '0, '0, '0, 1'b0};
        3: s = '{'1, '1, '1, '1, '1, '1, 1'b1};
        4: s = '{31'd50000, 31'd3000, 12'd300, 8'd200, 31'd500, 31'd2000, 1'b1};
        default: begin
          s.init_ms   = MsW'($urandom);
          s.max_ms    = MsW'($urandom);
          s.factor    = FactorW'($urandom);
          s.jfrac     = FracW'($urandom);
          s.fast_to   = MsW'($urandom);
          s.normal_to = MsW'($urandom);
          s.cache_ok  = 1'($urandom);
        end
      endcase
      load_setting(s);
      calm = (ph == 4);
      if (ph == 1) hold_requests++;
      random_events(PhaseEvents);
    end
    settle();

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/lrbc_pkg.sv
design/lrbc_datapath.sv
design/lrbc_ctrl.sv
design/link_reconnect_backoff_controller_core.sv
design/lrbc_checker.sv
tb/sv/link_reconnect_backoff_controller_core_tb.sv
